// ===== rtl/epr_pkg.sv =====
// Package for the escaped packet receiver.
// Holds the channel payload types, the register map and the parser state codes.
// No dependencies.
package epr_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic       framing_error;
        logic       overrun_error;
        logic [5:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic       packet_done;
        logic [6:0] packet_length;
        logic [7:0] source_address;
        logic [7:0] port_number;
        logic [7:0] read_data;
        logic [2:0] parser_state;
    } t_out_item;

    typedef struct packed {
        logic [7:0] esc_char;
        logic [7:0] hdr_char;
        logic [7:0] eof_char;
        logic [7:0] own_address;
    } t_cfg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ESCAPE = 2'd0;
    localparam logic [1:0] REG_HEADER = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;
    localparam logic [1:0] REG_OWN    = 2'd3;

    localparam logic [7:0] RST_ESCAPE = 8'd126;
    localparam logic [7:0] RST_HEADER = 8'd1;
    localparam logic [7:0] RST_END    = 8'd2;
    localparam logic [7:0] RST_OWN    = 8'd0;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // Parser state codes.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ESCAPE   = 3'd1;
    localparam logic [2:0] ST_HEADER   = 3'd2;
    localparam logic [2:0] ST_SOURCE   = 3'd3;
    localparam logic [2:0] ST_PORT     = 3'd4;
    localparam logic [2:0] ST_DATA     = 3'd5;
    localparam logic [2:0] ST_DATA_ESC = 3'd6;
    localparam logic [2:0] ST_UNUSED   = 3'd7;

endpackage

// ===== rtl/epr_cfg.sv =====
// APB-style configuration registers of the escaped packet receiver.
// Depends on epr_pkg for the register map and reset values.
module epr_cfg
    import epr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.esc_char    <= RST_ESCAPE;
            r_cfg.hdr_char    <= RST_HEADER;
            r_cfg.eof_char    <= RST_END;
            r_cfg.own_address <= RST_OWN;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ESCAPE: r_cfg.esc_char    <= pwdata[7:0];
                REG_HEADER: r_cfg.hdr_char    <= pwdata[7:0];
                REG_END:    r_cfg.eof_char    <= pwdata[7:0];
                REG_OWN:    r_cfg.own_address <= pwdata[7:0];
                default:    r_cfg.esc_char    <= r_cfg.esc_char;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ESCAPE: prdata = {24'd0, r_cfg.esc_char};
            REG_HEADER: prdata = {24'd0, r_cfg.hdr_char};
            REG_END:    prdata = {24'd0, r_cfg.eof_char};
            REG_OWN:    prdata = {24'd0, r_cfg.own_address};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/epr_parser.sv =====
// Frame parser of the escaped packet receiver: state, count, flags and buffer writes.
// Depends on epr_pkg for the item and configuration types and the state codes.
module epr_parser
    import epr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  t_in_item                        i_item,
    input  t_cfg                            i_cfg,
    output logic                            o_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                      o_wr_data,
    output logic [2:0]                      o_state,
    output logic [6:0]                      o_length,
    output logic                            o_done,
    output logic [7:0]                      o_sender,
    output logic [7:0]                      o_port
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_done, n_done;
    logic [7:0]    r_sender, n_sender;
    logic [7:0]    r_port, n_port;
    logic          store;
    logic [7:0]    b;
    logic          is_esc;
    logic [CW+6:0] count_ext;

    assign b      = i_item.rx_byte;
    assign is_esc = (b == i_cfg.esc_char);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = r_done;
        n_sender = r_sender;
        n_port   = r_port;
        store    = 1'b0;
        if (i_item.operation == OP_RECEIVE) begin
            if (i_item.framing_error || i_item.overrun_error) begin
                n_state = ST_IDLE;
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (is_esc) n_state = ST_ESCAPE;
                    end
                    ST_ESCAPE: begin
                        n_state = (b == i_cfg.hdr_char) ? ST_HEADER : ST_IDLE;
                    end
                    ST_HEADER: begin
                        // An address match wins over an escape of the same value.
                        if (b == i_cfg.own_address) n_state = ST_SOURCE;
                        else if (is_esc)            n_state = ST_ESCAPE;
                        else                        n_state = ST_IDLE;
                    end
                    ST_SOURCE: begin
                        if (is_esc) begin
                            n_state = ST_ESCAPE;
                        end else begin
                            n_state  = ST_PORT;
                            n_sender = b;
                            n_done   = 1'b0;
                            n_count  = '0;
                        end
                    end
                    ST_PORT: begin
                        if (is_esc) begin
                            n_state = ST_ESCAPE;
                        end else begin
                            n_state = ST_DATA;
                            n_port  = b;
                        end
                    end
                    ST_DATA: begin
                        if (r_count < DEPTH_C) begin
                            store   = 1'b1;
                            n_count = r_count + ONE_C;
                        end else begin
                            // Buffer full: the byte is dropped and the count
                            // steps back by one, closing the packet.
                            n_count = r_count - ONE_C;
                            n_state = ST_IDLE;
                            n_done  = 1'b1;
                        end
                        if (is_esc) n_state = ST_DATA_ESC;
                    end
                    ST_DATA_ESC: begin
                        if (is_esc) begin
                            n_state = ST_DATA;
                        end else if (b == i_cfg.eof_char) begin
                            n_done  = 1'b1;
                            n_state = ST_IDLE;
                            if (r_count != '0) n_count = r_count - ONE_C;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_sender <= 8'd0;
            r_port   <= 8'd0;
        end else if (i_accept) begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_done   <= n_done;
            r_sender <= n_sender;
            r_port   <= n_port;
        end
    end

    assign o_wr_en   = i_accept & store;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = b;

    assign count_ext = {7'd0, r_count};
    assign o_state   = r_state;
    assign o_length  = count_ext[6:0];
    assign o_done    = r_done;
    assign o_sender  = r_sender;
    assign o_port    = r_port;

endmodule

// ===== rtl/epr_buffer.sv =====
// Packet buffer of the escaped packet receiver: one write port, one registered read port.
// A write and a read of the same entry in one cycle forward the new byte.
// Depends on epr_pkg only by convention of the project; uses no package items.
module epr_buffer #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_accept,
    input  logic                            i_wr_en,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                      i_wr_data,
    input  logic [5:0]                      i_read_index,
    output logic [7:0]                      o_read_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [7:0]    r_mem_q;
    logic [7:0]    r_fwd_data;
    logic          r_fwd;
    logic          r_rd_ok;
    logic [AW+5:0] idx_ext;
    logic [AW-1:0] rd_addr;
    logic          rd_ok;

    assign idx_ext = {{AW{1'b0}}, i_read_index};
    assign rd_addr = idx_ext[AW-1:0];
    assign rd_ok   = (32'(i_read_index) < BUFFER_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) mem[i_wr_addr] <= i_wr_data;
        if (i_accept) r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_ok    <= rd_ok;
            r_fwd      <= i_wr_en && (i_wr_addr == rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_read_data = !r_rd_ok ? 8'd0 : (r_fwd ? r_fwd_data : r_mem_q);

endmodule

// ===== rtl/escaped_packet_receiver.sv =====
// Escaped packet receiver: parses byte-stuffed frames and stores their data bytes.
// Depends on epr_pkg, epr_cfg, epr_parser and epr_buffer.
//
// Each input transaction carries one received byte (or a buffer read) and yields
// exactly one result transaction, registered in the cycle after acceptance. A new
// transaction is taken every cycle (one item per clock) as long as the result
// register is empty or is being drained in the same cycle; the buffer is a
// single-port-write, single-port-read memory with a registered read, and a byte
// written in the same cycle as a read of its entry is forwarded. The result
// fields show the parser state after the byte; read_data is 0 for an index at
// or beyond BUFFER_DEPTH, entries unwritten since reset read as unspecified. The user must
// write configuration over the APB-style port only while idle; the block does not check it.
module escaped_packet_receiver
    import epr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    t_cfg          cfg;
    logic          accept;
    logic          r_valid;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [2:0]    state;
    logic [6:0]    length;
    logic          done;
    logic [7:0]    sender;
    logic [7:0]    port;
    logic [7:0]    read_data;

    assign pready  = 1'b1;
    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    epr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    epr_parser #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_data),
        .i_cfg     (cfg),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_state   (state),
        .o_length  (length),
        .o_done    (done),
        .o_sender  (sender),
        .o_port    (port)
    );

    epr_buffer #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_buffer (
        .i_clk        (i_clk),
        .i_accept     (accept),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_read_index (i_data.read_index),
        .o_read_data  (read_data)
    );

    // Parser registers change only on acceptance, so they hold the result of
    // the transaction currently shown on the output.
    assign o_valid               = r_valid;
    assign o_data.packet_done    = done;
    assign o_data.packet_length  = length;
    assign o_data.source_address = sender;
    assign o_data.port_number    = port;
    assign o_data.read_data      = read_data;
    assign o_data.parser_state   = state;

endmodule

// ===== rtl/epr_checker.sv =====
// Port-level checker for the escaped packet receiver, with its bind statement.
// Depends on epr_pkg for the payload types and state codes.
module epr_checker
    import epr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    logic in_acc;
    assign in_acc = i_valid && o_ready;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_valid)
        else $error("accepted transaction produced no result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    a_error_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.operation == OP_RECEIVE
         && (i_data.framing_error || i_data.overrun_error))
        |=> (o_data.parser_state == ST_IDLE))
        else $error("error byte did not return the parser to idle");

    a_port_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.parser_state == ST_PORT)
        |-> (!o_data.packet_done && o_data.packet_length == 7'd0))
        else $error("new frame did not clear done and length");

    a_no_unused_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.parser_state != ST_UNUSED))
        else $error("parser reached the unused state code");

endmodule

bind escaped_packet_receiver epr_checker u_epr_checker (.*);

// ===== test/escaped_packet_receiver_tb.sv =====
// Self-checking testbench for the escaped packet receiver.
// Drives random and directed byte streams, predicts every result and checks it.
// Depends on epr_pkg and escaped_packet_receiver.
`timescale 1ns / 1ps

module escaped_packet_receiver_tb;
    import epr_pkg::*;

    localparam int BUF_DEPTH = 64;
    localparam int N_PHASES = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic      data_known;
        t_out_item status;
    } t_status_exp;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Parser shadow state and the register values it runs with.
    t_cfg        cfg;
    logic [2:0]  prs_state;
    logic [7:0]  prs_store [BUF_DEPTH];
    bit          prs_written [BUF_DEPTH];
    logic [6:0]  prs_count;
    logic        prs_done;
    logic [7:0]  prs_sender;
    logic [7:0]  prs_port;

    t_in_item    pending_items [$];
    t_status_exp expected_status_q [$];
    t_in_item    next_item;
    t_status_exp got_exp;
    int          rx_items = 0;
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          sprinkle_reads = 0;

    escaped_packet_receiver #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("escaped_packet_receiver_tb NOT OK");
            $finish;
        end
    end

    // Advances the parser shadow by one transaction and queues the expected status.
    function automatic void predict_status(t_in_item it);
        t_status_exp e;
        logic [7:0] b;
        b = it.rx_byte;
        if (it.operation == OP_RECEIVE) begin
            if (it.framing_error || it.overrun_error) begin
                prs_state = ST_IDLE;
            end else begin
                case (prs_state)
                    ST_IDLE: begin
                        if (b == cfg.esc_char) prs_state = ST_ESCAPE;
                    end
                    ST_ESCAPE: begin
                        prs_state = (b == cfg.hdr_char) ? ST_HEADER : ST_IDLE;
                    end
                    ST_HEADER: begin
                        // The address match takes priority over the escape test.
                        if (b == cfg.own_address) prs_state = ST_SOURCE;
                        else if (b == cfg.esc_char) prs_state = ST_ESCAPE;
                        else prs_state = ST_IDLE;
                    end
                    ST_SOURCE: begin
                        if (b == cfg.esc_char) begin
                            prs_state = ST_ESCAPE;
                        end else begin
                            prs_state = ST_PORT;
                            prs_sender = b;
                            prs_done = 1'b0;
                            prs_count = '0;
                        end
                    end
                    ST_PORT: begin
                        if (b == cfg.esc_char) begin
                            prs_state = ST_ESCAPE;
                        end else begin
                            prs_state = ST_DATA;
                            prs_port = b;
                        end
                    end
                    ST_DATA: begin
                        if (prs_count < BUF_DEPTH) begin
                            prs_store[prs_count[5:0]] = b;
                            prs_written[prs_count[5:0]] = 1'b1;
                            prs_count = prs_count + 7'd1;
                        end else begin
                            if (prs_count != 0) prs_count = prs_count - 7'd1;
                            prs_state = ST_IDLE;
                            prs_done = 1'b1;
                        end
                        // Even an overflowing escape byte moves on to the data escape state.
                        if (b == cfg.esc_char) prs_state = ST_DATA_ESC;
                    end
                    ST_DATA_ESC: begin
                        if (b == cfg.esc_char) begin
                            prs_state = ST_DATA;
                        end else if (b == cfg.eof_char) begin
                            prs_done = 1'b1;
                            if (prs_count != 0) prs_count = prs_count - 7'd1;
                            prs_state = ST_IDLE;
                        end else begin
                            prs_state = ST_IDLE;
                        end
                    end
                    default: prs_state = ST_IDLE;
                endcase
            end
        end
        e.status.packet_done = prs_done;
        e.status.packet_length = prs_count;
        e.status.source_address = prs_sender;
        e.status.port_number = prs_port;
        e.status.read_data = prs_store[it.read_index];
        e.status.parser_state = prs_state;
        e.data_known = prs_written[it.read_index];
        expected_status_q.push_back(e);
    endfunction

    function automatic logic [5:0] any_written_index(logic [5:0] fallback);
        int start;
        int idx;
        start = $urandom_range(BUF_DEPTH - 1);
        for (int k = 0; k < BUF_DEPTH; k++) begin
            idx = (start + k) % BUF_DEPTH;
            if (prs_written[idx]) return idx[5:0];
        end
        return fallback;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver: one transaction in flight at most, held until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) predict_status(i_data);
            if (!i_valid || o_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_items.pop_front();
                    // Reads are steered to entries written since reset, where there are any.
                    if (!prs_written[next_item.read_index])
                        next_item.read_index = any_written_index(next_item.read_index);
                    i_data <= next_item;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_status_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, o_data);
                    errors++;
                end else begin
                    got_exp = expected_status_q.pop_front();
                    check_field("packet_done", got_exp.status.packet_done, o_data.packet_done);
                    check_field("packet_length", got_exp.status.packet_length,
                                o_data.packet_length);
                    check_field("source_address", got_exp.status.source_address,
                                o_data.source_address);
                    check_field("port_number", got_exp.status.port_number,
                                o_data.port_number);
                    check_field("parser_state", got_exp.status.parser_state,
                                o_data.parser_state);
                    if (got_exp.data_known)
                        check_field("read_data", got_exp.status.read_data, o_data.read_data);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_read(logic [7:0] b, bit ferr, bit oerr, logic [5:0] idx);
        t_in_item it;
        it.operation = OP_READ;
        it.rx_byte = b;
        it.framing_error = ferr;
        it.overrun_error = oerr;
        it.read_index = idx;
        pending_items.push_back(it);
    endtask

    task automatic queue_byte(logic [7:0] b, bit ferr, bit oerr);
        t_in_item it;
        if (sprinkle_reads && $urandom_range(15) == 0)
            queue_read(8'($urandom_range(255)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 6'($urandom_range(63)));
        it.operation = OP_RECEIVE;
        it.rx_byte = b;
        it.framing_error = ferr;
        it.overrun_error = oerr;
        it.read_index = 6'($urandom_range(63));
        pending_items.push_back(it);
        if (!ferr && !oerr) rx_items++;
    endtask

    // A complete frame; a broken one has an error byte, a wrong byte or is cut short.
    task automatic queue_frame(int n_data, bit broken);
        logic [7:0] seq [$];
        logic [7:0] v;
        int cut;
        int how;
        bit ferr;
        seq.push_back(cfg.esc_char);
        seq.push_back(cfg.hdr_char);
        seq.push_back(cfg.own_address);
        do v = 8'($urandom_range(255)); while (v == cfg.esc_char);
        seq.push_back(v);
        do v = 8'($urandom_range(255)); while (v == cfg.esc_char);
        seq.push_back(v);
        for (int i = 0; i < n_data; i++) begin
            v = 8'($urandom_range(255));
            // Often put an escape right at the overflow point.
            if ($urandom_range(7) == 0 || (i == BUF_DEPTH && $urandom_range(1) == 0))
                v = cfg.esc_char;
            seq.push_back(v);
            if (v == cfg.esc_char) seq.push_back(v);
        end
        seq.push_back(cfg.esc_char);
        seq.push_back(cfg.eof_char);
        cut = broken ? $urandom_range(seq.size() - 1) : seq.size();
        how = $urandom_range(2);
        for (int i = 0; i < seq.size(); i++) begin
            if (i == cut && how == 2) break;
            if (i == cut && how == 1) begin
                queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            end else if (i == cut) begin
                ferr = 1'($urandom_range(1));
                queue_byte(seq[i], ferr, ferr ? 1'($urandom_range(1)) : 1'b1);
            end else begin
                queue_byte(seq[i], 1'b0, 1'b0);
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ESCAPE: cfg.esc_char = value;
            REG_HEADER: cfg.hdr_char = value;
            REG_END:    cfg.eof_char = value;
            REG_OWN:    cfg.own_address = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_status_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    initial begin
        t_cfg next_cfg;
        int goal;
        int kind;
        cfg = {RST_ESCAPE, RST_HEADER, RST_END, RST_OWN};
        prs_state = ST_IDLE;
        prs_count = '0;
        prs_done = 1'b0;
        prs_sender = '0;
        prs_port = '0;
        for (int i = 0; i < BUF_DEPTH; i++) begin
            prs_store[i] = '0;
            prs_written[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: next_cfg = {8'h5A, 8'h00, 8'hFF, 8'h5A};  // address equals escape
                    2: next_cfg = {8'h00, 8'hFF, 8'h01, 8'hFF};
                    3: next_cfg = {8'hFF, 8'h00, 8'h00, 8'h00};
                    default: next_cfg = $urandom;
                endcase
                write_reg(REG_ESCAPE, next_cfg.esc_char);
                write_reg(REG_HEADER, next_cfg.hdr_char);
                write_reg(REG_END, next_cfg.eof_char);
                write_reg(REG_OWN, next_cfg.own_address);
                @(negedge i_clk);
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase

            if (p == 0) begin
                sprinkle_reads = 0;
                // Full frame with extreme bytes, a doubled escape and the end code.
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(cfg.hdr_char, 1'b0, 1'b0);
                queue_byte(cfg.own_address, 1'b0, 1'b0);
                queue_byte(8'hFF, 1'b0, 1'b0);
                queue_byte(8'h00, 1'b0, 1'b0);
                queue_byte(8'h00, 1'b0, 1'b0);
                queue_byte(8'hFF, 1'b0, 1'b0);
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(cfg.eof_char, 1'b0, 1'b0);
                // A read transaction leaves the parser alone whatever its flags say.
                queue_read(8'hFF, 1'b1, 1'b1, 6'd63);
                // Error bytes send the parser back to idle.
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(cfg.hdr_char, 1'b1, 1'b0);
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(cfg.hdr_char, 1'b0, 1'b0);
                queue_byte(cfg.own_address, 1'b0, 1'b1);
                // Escape seen in the source state, then in the port state.
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(cfg.hdr_char, 1'b0, 1'b0);
                queue_byte(cfg.own_address, 1'b0, 1'b0);
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(cfg.hdr_char, 1'b0, 1'b0);
                queue_byte(cfg.own_address, 1'b0, 1'b0);
                queue_byte(8'h11, 1'b0, 1'b0);
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                // Data escape followed by an ordinary byte abandons the frame.
                queue_byte(cfg.hdr_char, 1'b0, 1'b0);
                queue_byte(cfg.own_address, 1'b0, 1'b0);
                queue_byte(8'h22, 1'b0, 1'b0);
                queue_byte(8'h33, 1'b0, 1'b0);
                queue_byte(cfg.esc_char, 1'b0, 1'b0);
                queue_byte(8'h44, 1'b0, 1'b0);
            end

            sprinkle_reads = 1;
            goal = rx_items + 30;
            if (p % 2 == 1) queue_frame(BUF_DEPTH + 1 + $urandom_range(6), 1'b0);
            while (rx_items < goal) begin
                kind = $urandom_range(99);
                if (kind < 70) begin
                    queue_frame(($urandom_range(29) == 0) ? BUF_DEPTH + 1 + $urandom_range(6)
                                                          : $urandom_range(12), 1'b0);
                end else if (kind < 85) begin
                    queue_frame($urandom_range(12), 1'b1);
                end else begin
                    repeat ($urandom_range(4, 1)) begin
                        if ($urandom_range(3) == 0)
                            queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                                       1'($urandom_range(1)));
                        else
                            queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
                    end
                end
            end
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (errors == 0 && expected_status_q.size() == 0) begin
            $display("escaped_packet_receiver_tb OK");
        end else begin
            $display("escaped_packet_receiver_tb NOT OK");
        end
        $finish;
    end

endmodule
